### rtl/oll_pkg.sv
// Shared types and constants for the ordered list engine.
// No dependencies; every other file imports this package.
package oll_pkg;

    // Index width that covers the largest supported list (256 entries plus a count of 256).
    localparam int LIST_IDX_W = 9;
    localparam int DATA_W     = 32;
    localparam int POS_W      = 5;
    localparam int STAT_W     = 3;
    localparam int SCAN_LANES = 8;

    localparam logic [1:0] CMD_INS_FRONT = 2'd0;
    localparam logic [1:0] CMD_INS_REAR  = 2'd1;
    localparam logic [1:0] CMD_DELETE    = 2'd2;
    localparam logic [1:0] CMD_SEARCH    = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

    typedef logic [1:0] t_op;
    localparam t_op OP_NONE  = 2'd0;
    localparam t_op OP_FRONT = 2'd1;
    localparam t_op OP_REAR  = 2'd2;
    localparam t_op OP_DEL   = 2'd3;

    // Broadcast from the control logic to every cell of the chain.
    typedef struct packed {
        t_op                         op;
        logic [LIST_IDX_W-1:0]       count;
        logic [LIST_IDX_W-1:0]       del_idx;
        logic signed [DATA_W-1:0]    value;
        logic signed [DATA_W-1:0]    key;
    } t_cell_ctrl;

    // Current view of the match scanner.
    typedef struct packed {
        logic                        busy;
        logic                        done;
        logic                        found;
        logic [LIST_IDX_W-1:0]       idx;
    } t_scan_res;

endpackage

### rtl/oll_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on oll_pkg for field widths.
interface oll_in_if import oll_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               command;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] key;

    modport source (output valid, command, value, position, key, input ready);
    modport sink   (input valid, command, value, position, key, output ready);
endinterface

interface oll_out_if import oll_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STAT_W-1:0]    status;
    logic [POS_W-1:0]     found_position;
    logic [POS_W-1:0]     entry_count;

    modport source (output valid, status, found_position, entry_count, input ready);
    modport sink   (input valid, status, found_position, entry_count, output ready);
endinterface

### rtl/oll_cell.sv
// One storage cell of the list chain: holds one entry, shifts with its neighbors.
// Depends on oll_pkg.
module oll_cell import oll_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic                     i_clk,
    input  t_cell_ctrl               i_ctrl,
    input  logic signed [DATA_W-1:0] i_left_data,
    input  logic signed [DATA_W-1:0] i_right_data,
    output logic signed [DATA_W-1:0] o_data,
    output logic                     o_match
);

    localparam logic [LIST_IDX_W-1:0] MY_IDX = LIST_IDX_W'(IDX);

    logic signed [DATA_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            OP_FRONT: r_data <= i_left_data;
            OP_REAR: begin
                if (MY_IDX == i_ctrl.count) begin
                    r_data <= i_ctrl.value;
                end
            end
            OP_DEL: begin
                if (MY_IDX >= i_ctrl.del_idx) begin
                    r_data <= i_right_data;
                end
            end
            default: r_data <= r_data;
        endcase
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_ctrl.key) && (MY_IDX < i_ctrl.count);

endmodule

### rtl/oll_scan.sv
// First-match scanner: walks the captured match bits eight cells per cycle while i_adv is high.
// Depends on oll_pkg.
module oll_scan import oll_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_adv,
    input  logic [DEPTH-1:0] i_match,
    output t_scan_res        o_res
);

    localparam int GROUPS = (DEPTH + SCAN_LANES - 1) / SCAN_LANES;
    localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int VW     = GROUPS * SCAN_LANES;

    logic [VW-1:0]  r_vec;
    logic [GW-1:0]  r_grp;
    logic           r_busy;
    logic [2:0]     w_lane;
    logic           w_hit;
    logic           w_last;

    always_comb begin
        w_lane = 3'd0;
        for (int k = SCAN_LANES - 1; k >= 0; k--) begin
            if (r_vec[k]) begin
                w_lane = 3'(k);
            end
        end
    end

    assign w_hit  = |r_vec[SCAN_LANES-1:0];
    assign w_last = (r_grp == GW'(GROUPS - 1));

    assign o_res.busy  = r_busy;
    assign o_res.done  = r_busy && (w_hit || w_last);
    assign o_res.found = w_hit;
    assign o_res.idx   = (LIST_IDX_W'(r_grp) << 3) | LIST_IDX_W'(w_lane);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (i_adv && o_res.done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_vec <= VW'(i_match);
            r_grp <= '0;
        end else if (i_adv && r_busy) begin
            r_vec <= r_vec >> SCAN_LANES;
            r_grp <= r_grp + GW'(1);
        end
    end

endmodule

### rtl/ordered_list_engine_top.sv
// Ordered list engine top level: control, count, response register and the cell chain.
// Depends on oll_pkg, oll_if, oll_cell and oll_scan.
//
// The list is a chain of DEPTH cells, one entry per cell, front at cell 0. Insert front,
// insert rear and delete are applied by all cells at once in the cycle the request
// transaction is accepted, and the response appears in the next cycle; such requests can
// be taken every cycle while responses are drained. A search compares all cells in the
// accept cycle, then the match scanner examines eight cells per cycle, pausing on its final
// step until the response register is free; no request is taken during a search. The block
// needs no clearing after reset; positions and counts are reported in the low five bits.
module ordered_list_engine_top import oll_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    oll_in_if.sink    i_req,
    oll_out_if.source o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                     r_state;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic                     r_out_valid;
    logic [STAT_W-1:0]        r_status;
    logic [POS_W-1:0]         r_found;
    logic [POS_W-1:0]         r_cnt_out;

    logic                     w_out_free;
    logic                     w_acc;
    logic [LIST_IDX_W-1:0]    w_cnt_ext;
    logic [LIST_IDX_W-1:0]    w_pos_ext;
    logic [LIST_IDX_W-1:0]    w_new_cnt;
    logic                     w_full;
    logic                     w_empty;
    t_op                      w_op;
    logic [STAT_W-1:0]        w_status;
    logic                     w_start;
    t_cell_ctrl               w_ctrl;
    t_scan_res                w_scan;
    logic                     w_adv;
    logic                     w_scan_out;
    logic signed [DATA_W-1:0] w_data [DEPTH];
    logic [DEPTH-1:0]         w_match;

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && w_out_free;
    assign w_acc       = i_req.valid && i_req.ready;

    assign w_cnt_ext = LIST_IDX_W'(r_count);
    assign w_pos_ext = LIST_IDX_W'(i_req.position);
    assign w_full    = (w_cnt_ext == LIST_IDX_W'(DEPTH));
    assign w_empty   = (w_cnt_ext == '0);

    always_comb begin
        w_op      = OP_NONE;
        w_status  = ST_OK;
        w_new_cnt = w_cnt_ext;
        w_start   = 1'b0;
        unique case (i_req.command)
            CMD_INS_FRONT, CMD_INS_REAR: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op      = (i_req.command == CMD_INS_FRONT) ? OP_FRONT : OP_REAR;
                    w_new_cnt = w_cnt_ext + LIST_IDX_W'(1);
                end
            end
            CMD_DELETE: begin
                priority if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_pos_ext == '0 || w_pos_ext > w_cnt_ext) begin
                    w_status = ST_BADPOS;
                end else begin
                    w_op      = OP_DEL;
                    w_new_cnt = w_cnt_ext - LIST_IDX_W'(1);
                end
            end
            default: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_start = 1'b1;
                end
            end
        endcase
    end

    assign n_count = CW'(w_new_cnt);

    assign w_ctrl.op      = w_acc ? w_op : OP_NONE;
    assign w_ctrl.count   = w_cnt_ext;
    assign w_ctrl.del_idx = w_pos_ext - LIST_IDX_W'(1);
    assign w_ctrl.value   = i_req.value;
    assign w_ctrl.key     = i_req.key;

    // Cell 0 takes the new value on a front insert; the last cell refills with don't-care
    // data on a delete, which lies beyond the count.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = i_req.value;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end
        oll_cell #(.IDX(g)) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_left_data (w_left),
            .i_right_data(w_right),
            .o_data      (w_data[g]),
            .o_match     (w_match[g])
        );
    end

    oll_scan #(.DEPTH(DEPTH)) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_acc && w_start),
        .i_adv   (w_adv),
        .i_match (w_match),
        .o_res   (w_scan)
    );

    // The scan pauses on its final step until the response register can take the result.
    assign w_adv      = (r_state == S_SCAN) && (!w_scan.done || w_out_free);
    assign w_scan_out = (r_state == S_SCAN) && w_scan.done && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count <= n_count;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc && w_start) begin
                        r_state <= S_SCAN;
                    end
                end
                default: begin
                    if (w_scan_out) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
            if ((w_acc && !w_start) || w_scan_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && !w_start) begin
            r_status  <= w_status;
            r_found   <= '0;
            r_cnt_out <= w_new_cnt[POS_W-1:0];
        end else if (w_scan_out) begin
            r_status  <= w_scan.found ? ST_OK : ST_NOTFOUND;
            r_found   <= w_scan.found ? POS_W'(w_scan.idx + LIST_IDX_W'(1)) : '0;
            r_cnt_out <= w_cnt_ext[POS_W-1:0];
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_status;
    assign o_rsp.found_position = r_found;
    assign o_rsp.entry_count    = r_cnt_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt_ext <= LIST_IDX_W'(DEPTH))
        else $error("entry count exceeds list depth");

    a_no_accept_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !i_req.ready)
        else $error("request taken while a search is in progress");

    a_scanner_tracks_fsm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) == w_scan.busy)
        else $error("scanner and control state disagree");

    a_direct_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_start) |=> (o_rsp.valid && o_rsp.found_position == '0))
        else $error("non-search request did not produce its response");

endmodule
